@@ src/iirdf1_pkg.sv @@
// Shared types and constants for the direct form I IIR filter core.
// Used by iirdf1_mac and iir_filter_direct_form_one_core; no dependencies.
package iirdf1_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int FRAC_W   = 15;

  // Action codes carried in the input tuser.
  localparam logic [1:0] ACT_SAMPLE  = 2'd0;
  localparam logic [1:0] ACT_LOAD_FF = 2'd1;
  localparam logic [1:0] ACT_LOAD_FB = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_FF_TERMS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_TERMS = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FF,
    S_FB,
    S_DRAIN,
    S_ROUND
  } state_t;

  // Controls from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic start;    // clear the accumulator for a new sample
    logic mul_en;   // operands are valid this cycle
    logic mul_sub;  // subtract this product (feedback term)
  } mac_ctl_t;

endpackage

@@ src/iirdf1_mac.sv @@
// Shared multiply-accumulate unit with rounding and saturation.
// Depends on iirdf1_pkg.
module iirdf1_mac #(
  parameter int ACC_W = 40
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  iirdf1_pkg::mac_ctl_t                    ctl,
  input  logic signed [iirdf1_pkg::COEF_W-1:0]    coef,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0]  data,
  output logic                                    busy,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0]  result,
  output logic                                    sat
);

  localparam int PW = iirdf1_pkg::PROD_W;
  localparam int SW = iirdf1_pkg::SAMPLE_W;
  localparam int FW = iirdf1_pkg::FRAC_W;

  logic signed [PW-1:0]  prod_r;
  logic                  prod_vld_r;
  logic                  prod_sub_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W:0]   rnd;
  logic signed [ACC_W:0]   quo;
  logic signed [ACC_W:0]   max_v;
  logic signed [ACC_W:0]   min_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      prod_sub_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.mul_en;
      prod_sub_r <= ctl.mul_sub;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= PW'(coef * data);
    end
  end

  assign prod_ext = ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= prod_sub_r ? acc_r - prod_ext : acc_r + prod_ext;
    end
  end

  // Round half up to Q1.15: add half an LSB, then floor by an arithmetic shift.
  assign rnd   = (ACC_W+1)'(acc_r) + (ACC_W+1)'(1 << (FW - 1));
  assign quo   = rnd >>> FW;
  assign max_v = (ACC_W+1)'((1 << (SW - 1)) - 1);
  assign min_v = -(ACC_W+1)'(1 << (SW - 1));

  always_comb begin
    if (quo > max_v) begin
      result = SW'(max_v);
      sat    = 1'b1;
    end else if (quo < min_v) begin
      result = SW'(min_v);
      sat    = 1'b1;
    end else begin
      result = SW'(quo);
      sat    = 1'b0;
    end
  end

  assign busy = prod_vld_r;

endmodule

@@ src/iir_filter_direct_form_one_core.sv @@
// Top level of the direct form I IIR filter: sequencer, coefficient and history
// memories, stream ports and configuration registers. Depends on iirdf1_pkg, iirdf1_mac.
//
//  Channel  Direction  Signals                      Payload
//  in_      slave      tvalid/tready/tdata/tuser    sample or coefficient load
//  out_     master     tvalid/tready/tdata/tuser    filtered sample and clip flag
//  cfg_     write      we/index/data                feedforward_terms, feedback_terms
//
// An accepted sample runs through the feedforward taps, the feedback taps, a drain of
// the pipeline and rounding into the output register; no new item is taken until it
// has finished. The single shared multiplier takes one tap a cycle, followed by the
// memory read, product and accumulate pipeline registers and a rounding state. A
// coefficient load leaves the sequencer idle. Reset clears the histories through valid
// bits at once, with no clearing pass. A stalled output holds the finished sample
// in the output register; the next item is accepted meanwhile.
module iir_filter_direct_form_one_core #(
  parameter int TAPS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: coef_index[2:0], coef_value[20:3], sample_in[36:21], restart[37], zero pad
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  // tuser: action[1:0]
  input  logic [1:0]  in_tuser,
  // tdata: sample_out[15:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  // tuser: saturated[0]
  output logic [0:0]  out_tuser,
  input  logic                                  cfg_we,
  input  logic [iirdf1_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [iirdf1_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SW    = iirdf1_pkg::SAMPLE_W;
  localparam int CFW   = iirdf1_pkg::COEF_W;
  localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CW    = $clog2(TAPS + 1);
  localparam int CMPW  = (CW > 4) ? CW : 4;
  localparam int IXW   = (AW > 3) ? AW + 1 : 4;
  localparam int ACC_W = iirdf1_pkg::PROD_W + $clog2(2 * TAPS) + 1;

  // Input field unpacking.
  logic [1:0]            in_action;
  logic [2:0]            in_coef_index;
  logic signed [CFW-1:0] in_coef_value;
  logic signed [SW-1:0]  in_sample;
  logic                  in_restart;

  assign in_action     = in_tuser;
  assign in_coef_index = in_tdata[2:0];
  assign in_coef_value = in_tdata[20:3];
  assign in_sample     = in_tdata[36:21];
  assign in_restart    = in_tdata[37];

  // Configuration registers.
  logic [3:0] ff_terms_r;
  logic [2:0] fb_terms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_terms_r <= 4'd1;
      fb_terms_r <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        iirdf1_pkg::CFG_FF_TERMS: ff_terms_r <= cfg_data[3:0];
        iirdf1_pkg::CFG_FB_TERMS: fb_terms_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Tap counts clamped to what the memories hold.
  logic [CMPW-1:0] ff_wide;
  logic [CMPW-1:0] fb_wide;
  logic [CW-1:0]   ff_eff;
  logic [CW-1:0]   fb_eff;

  always_comb begin
    ff_wide = (CMPW'(ff_terms_r) > CMPW'(TAPS)) ? CMPW'(TAPS) : CMPW'(ff_terms_r);
    fb_wide = (CMPW'(fb_terms_r) > CMPW'(TAPS - 1)) ? CMPW'(TAPS - 1) : CMPW'(fb_terms_r);
    ff_eff  = ff_wide[CW-1:0];
    fb_eff  = fb_wide[CW-1:0];
  end

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(TAPS - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(TAPS - 1) : p - AW'(1);
  endfunction

  // Sequencer.
  iirdf1_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]  hp_r, hp_nxt;
  logic [AW-1:0]  xwp_r, xwp_nxt;
  logic [AW-1:0]  ywp_r, ywp_nxt;
  logic [TAPS-1:0] xv_r, xv_nxt;
  logic [TAPS-1:0] yv_r, yv_nxt;

  logic in_fire;
  logic smp_fire;
  logic issue;
  logic issue_fb;
  logic round_go;
  logic ff_last;
  logic fb_last;
  logic [CW-1:0] cnt_inc;
  logic [AW-1:0] fb_addr;
  logic [AW-1:0] xw_addr;
  logic [AW-1:0] yw_addr;

  logic                 rd_vld_r;
  logic                 rd_fb_r;
  logic                 hv_r;
  logic signed [CFW-1:0] b_rd_r;
  logic signed [CFW-1:0] a_rd_r;
  logic signed [SW-1:0]  xh_rd_r;
  logic signed [SW-1:0]  yh_rd_r;

  logic                  mac_busy;
  logic signed [SW-1:0]  mac_y;
  logic                  mac_sat;
  iirdf1_pkg::mac_ctl_t  mac_ctl;

  logic                  out_valid_r;
  logic [SW-1:0]         out_data_r;
  logic                  out_sat_r;

  assign in_fire  = in_tvalid && in_tready;
  assign smp_fire = in_fire && (in_action == iirdf1_pkg::ACT_SAMPLE);
  assign cnt_inc  = cnt_r + CW'(1);
  assign ff_last  = (cnt_inc == ff_eff);
  assign fb_last  = (cnt_inc == fb_eff);
  assign fb_addr  = cnt_inc[AW-1:0];
  assign xw_addr  = ptr_inc(xwp_r);
  assign yw_addr  = ptr_inc(ywp_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      iirdf1_pkg::S_IDLE: begin
        if (smp_fire) begin
          if (ff_eff != '0) begin
            state_nxt = iirdf1_pkg::S_FF;
          end else if (fb_eff != '0) begin
            state_nxt = iirdf1_pkg::S_FB;
          end else begin
            state_nxt = iirdf1_pkg::S_DRAIN;
          end
        end
      end
      iirdf1_pkg::S_FF: begin
        if (ff_last) begin
          state_nxt = (fb_eff != '0) ? iirdf1_pkg::S_FB : iirdf1_pkg::S_DRAIN;
        end
      end
      iirdf1_pkg::S_FB: begin
        if (fb_last) begin
          state_nxt = iirdf1_pkg::S_DRAIN;
        end
      end
      iirdf1_pkg::S_DRAIN: begin
        if (!rd_vld_r && !mac_busy) begin
          state_nxt = iirdf1_pkg::S_ROUND;
        end
      end
      iirdf1_pkg::S_ROUND: begin
        if (round_go) begin
          state_nxt = iirdf1_pkg::S_IDLE;
        end
      end
      default: state_nxt = iirdf1_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs. No transaction is taken while reset is held.
  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    issue_fb  = 1'b0;
    round_go  = 1'b0;
    case (state_r)
      iirdf1_pkg::S_IDLE:  in_tready = rst_n;
      iirdf1_pkg::S_FF:    issue = 1'b1;
      iirdf1_pkg::S_FB: begin
        issue    = 1'b1;
        issue_fb = 1'b1;
      end
      iirdf1_pkg::S_DRAIN: ;
      iirdf1_pkg::S_ROUND: round_go = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // Tap counter, history pointers and valid bits.
  always_comb begin
    cnt_nxt = cnt_r;
    hp_nxt  = hp_r;
    xwp_nxt = xwp_r;
    ywp_nxt = ywp_r;
    xv_nxt  = xv_r;
    yv_nxt  = yv_r;
    if (smp_fire) begin
      // A restart drops both histories; the new sample is then the only valid entry.
      if (in_restart) begin
        xv_nxt = '0;
        yv_nxt = '0;
      end
      xv_nxt[xw_addr] = 1'b1;
      xwp_nxt = xw_addr;
      cnt_nxt = '0;
      hp_nxt  = (ff_eff != '0) ? xw_addr : ywp_r;
    end else if (issue) begin
      if ((!issue_fb && ff_last) || (issue_fb && fb_last)) begin
        // Feedback walks back from the newest output, y[n-1].
        cnt_nxt = '0;
        hp_nxt  = ywp_r;
      end else begin
        cnt_nxt = cnt_inc;
        hp_nxt  = ptr_dec(hp_r);
      end
    end else if (round_go) begin
      yv_nxt[yw_addr] = 1'b1;
      ywp_nxt = yw_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iirdf1_pkg::S_IDLE;
      cnt_r   <= '0;
      hp_r    <= '0;
      xwp_r   <= '0;
      ywp_r   <= '0;
      xv_r    <= '0;
      yv_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      hp_r    <= hp_nxt;
      xwp_r   <= xwp_nxt;
      ywp_r   <= ywp_nxt;
      xv_r    <= xv_nxt;
      yv_r    <= yv_nxt;
    end
  end

  // Coefficient memories. Feedback entry 0 stays unused, since a0 is one.
  logic signed [CFW-1:0] b_mem [TAPS];
  logic signed [CFW-1:0] a_mem [TAPS];
  logic [IXW-1:0]        ld_idx;

  assign ld_idx = IXW'(in_coef_index);

  always_ff @(posedge clk) begin
    if (in_fire && (in_action == iirdf1_pkg::ACT_LOAD_FF) && (ld_idx < IXW'(TAPS))) begin
      b_mem[ld_idx[AW-1:0]] <= in_coef_value;
    end
    if (issue) begin
      b_rd_r <= b_mem[cnt_r[AW-1:0]];
    end
  end

  logic [IXW-1:0] ld_idx_fb;
  assign ld_idx_fb = ld_idx + IXW'(1);

  always_ff @(posedge clk) begin
    if (in_fire && (in_action == iirdf1_pkg::ACT_LOAD_FB) && (ld_idx_fb < IXW'(TAPS))) begin
      a_mem[ld_idx_fb[AW-1:0]] <= in_coef_value;
    end
    if (issue) begin
      a_rd_r <= a_mem[fb_addr];
    end
  end

  // History memories, written as circular buffers.
  logic signed [SW-1:0] xh_mem [TAPS];
  logic signed [SW-1:0] yh_mem [TAPS];

  always_ff @(posedge clk) begin
    if (smp_fire) begin
      xh_mem[xw_addr] <= in_sample;
    end
    if (issue) begin
      xh_rd_r <= xh_mem[hp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (round_go) begin
      yh_mem[yw_addr] <= mac_y;
    end
    if (issue) begin
      yh_rd_r <= yh_mem[hp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      rd_fb_r  <= 1'b0;
      hv_r     <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      rd_fb_r  <= issue_fb;
      hv_r     <= issue_fb ? yv_r[hp_r] : xv_r[hp_r];
    end
  end

  // Shared multiply-accumulate. A history entry that is not valid reads as zero.
  logic signed [CFW-1:0] mac_coef;
  logic signed [SW-1:0]  mac_data;

  assign mac_ctl.start   = smp_fire;
  assign mac_ctl.mul_en  = rd_vld_r;
  assign mac_ctl.mul_sub = rd_fb_r;
  assign mac_coef        = rd_fb_r ? a_rd_r : b_rd_r;
  assign mac_data        = !hv_r ? '0 : (rd_fb_r ? yh_rd_r : xh_rd_r);

  iirdf1_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .coef   (mac_coef),
    .data   (mac_data),
    .busy   (mac_busy),
    .result (mac_y),
    .sat    (mac_sat)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (round_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (round_go) begin
      out_data_r <= mac_y;
      out_sat_r  <= mac_sat;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_sat_r;

  // The read pipe and the multiplier are empty whenever a new item can be taken.
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iirdf1_pkg::S_IDLE) |-> (!rd_vld_r && !mac_busy))
    else $error("tap pipeline busy while idle");

  // Rounding only sees a fully accumulated sum.
  a_round_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == iirdf1_pkg::S_ROUND) |-> (!rd_vld_r && !mac_busy))
    else $error("rounding before the accumulator settled");

  // An accepted sample always starts a computation.
  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    smp_fire |=> (state_r != iirdf1_pkg::S_IDLE))
    else $error("sample accepted without a computation");

  // The tap counter stays within the memory depth.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (cnt_r < CW'(TAPS)))
    else $error("tap counter out of range");

  // A finished sample never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    round_go |-> (!out_valid_r || out_tready))
    else $error("output register overwritten");

endmodule

@@ tb/iir_filter_direct_form_one_core_tb.sv @@
// Self-checking testbench for the direct form I IIR filter core.
// Depends on iirdf1_pkg and the core RTL; a built-in fixed-point predictor checks every output.
module iir_filter_direct_form_one_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS = 8;
  // Generous margin for pipeline drain after the longest sample.
  localparam int DRAIN_CYCLES = 40;
  // Cycles without any accepted transaction on either stream before giving up.
  localparam int WATCHDOG_LIMIT = 2000;
  // Action and register codes, taken from the package.
  localparam logic [1:0] ACT_SAMPLE  = iirdf1_pkg::ACT_SAMPLE;
  localparam logic [1:0] ACT_LOAD_FF = iirdf1_pkg::ACT_LOAD_FF;
  localparam logic [1:0] ACT_LOAD_FB = iirdf1_pkg::ACT_LOAD_FB;
  localparam int CFG_IDX_W  = iirdf1_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = iirdf1_pkg::CFG_DATA_W;
  localparam logic [CFG_IDX_W-1:0] CFG_FF_TERMS = iirdf1_pkg::CFG_FF_TERMS;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_TERMS = iirdf1_pkg::CFG_FB_TERMS;
  // The one action code the core must ignore.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // One input transaction plus, for hand-written rows, the result it must give.
  typedef struct {
    logic [1:0]         action;
    logic [2:0]         coef_index;
    logic signed [17:0] coef_value;
    logic signed [15:0] sample_in;
    logic               restart;
    logic               fixed_exp;
    logic [15:0]        exp_sample;
    logic               exp_sat;
  } stim_t;

  typedef struct {
    logic [15:0] sample_out;
    logic        saturated;
  } result_t;

  // Tap counts, handshake pressure and length of one random phase.
  typedef struct {
    logic [3:0] ff;
    logic [2:0] fb;
    int         send_idle;
    int         rx_stall;
    int         hold;
    int         items;
  } phase_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: sample and output histories, coefficient banks, tap counts.
  logic signed [15:0] x_hist [TAPS];
  logic signed [15:0] y_hist [TAPS];
  logic signed [17:0] b_coef [TAPS];
  logic signed [17:0] a_coef [TAPS];
  logic [3:0]         ff_terms;
  logic [2:0]         fb_terms;

  // Filter outputs predicted but not yet seen on the output stream, oldest first.
  result_t pending_outputs [$];

  int send_idle_pct = 0;
  int rx_stall_pct  = 0;
  int hold_request  = 0;
  int error_count   = 0;

  stim_t  directed_tbl [26];
  phase_t phase_tbl [6];

  iir_filter_direct_form_one_core #(
    .TAPS(TAPS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Filters one sample through the predictor. Products are Q3.30 and summed exactly;
  // the sum is rounded half up to Q1.15 by an arithmetic shift (a floor) and then
  // clipped. The output history keeps the clipped value, as the hardware does.
  function automatic result_t filter_sample(input logic signed [15:0] x,
                                            input logic restart);
    result_t res;
    longint  acc;
    longint  rounded;
    int      nf;
    int      nb;
    int      k;
    if (restart) begin
      for (k = 0; k < TAPS; k++) begin
        x_hist[k] = '0;
        y_hist[k] = '0;
      end
    end
    for (k = TAPS - 1; k > 0; k--) x_hist[k] = x_hist[k - 1];
    x_hist[0] = x;
    // Tap counts beyond what the core holds act as the maximum.
    nf = (ff_terms > TAPS) ? TAPS : int'(ff_terms);
    nb = (fb_terms > TAPS - 1) ? TAPS - 1 : int'(fb_terms);
    acc = 0;
    for (k = 0; k < nf; k++) acc += longint'(b_coef[k]) * longint'(x_hist[k]);
    for (k = 1; k <= nb; k++) acc -= longint'(a_coef[k]) * longint'(y_hist[k - 1]);
    rounded = (acc + 64'sd16384) >>> 15;
    res.saturated = 1'b0;
    if (rounded > 32767) begin
      rounded = 32767;
      res.saturated = 1'b1;
    end else if (rounded < -32768) begin
      rounded = -32768;
      res.saturated = 1'b1;
    end
    for (k = TAPS - 1; k > 0; k--) y_hist[k] = y_hist[k - 1];
    y_hist[0] = rounded[15:0];
    res.sample_out = rounded[15:0];
    return res;
  endfunction

  // Applies an accepted transaction to the predictor. Loads update a coefficient bank
  // (a feedback index of 7 would be a8, which an 8-tap core drops); a sample queues
  // its expected output; the unused action does nothing.
  task automatic apply_item(input stim_t s);
    result_t r;
    case (s.action)
      ACT_LOAD_FF: begin
        if (int'(s.coef_index) < TAPS) b_coef[s.coef_index] = s.coef_value;
      end
      ACT_LOAD_FB: begin
        if (int'(s.coef_index) + 1 < TAPS) a_coef[int'(s.coef_index) + 1] = s.coef_value;
      end
      ACT_SAMPLE: begin
        r = filter_sample(s.sample_in, s.restart);
        // Hand-written rows still run through the predictor to keep its history right,
        // but are held to the value typed into the table.
        if (s.fixed_exp) begin
          r.sample_out = s.exp_sample;
          r.saturated  = s.exp_sat;
        end
        pending_outputs.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  // Drives one transaction on the input stream, inserting random idle cycles first.
  // Valid is only ever set once per time step, so back-to-back transactions keep it
  // high without a glitch.
  task automatic offer(input stim_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= s.action;
    in_tdata  <= {2'b00, s.restart, s.sample_in, s.coef_value, s.coef_index};
    do @(posedge clk); while (!in_tready);
    apply_item(s);
  endtask

  // Both tap-count registers are written back to back; the enable stays high across
  // the two writes and drops once afterward.
  task automatic write_tap_counts(input logic [3:0] ff, input logic [2:0] fb);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FF_TERMS;
    cfg_data  <= ff;
    @(posedge clk);
    cfg_index <= CFG_FB_TERMS;
    cfg_data  <= {1'b0, fb};
    @(posedge clk);
    cfg_we <= 1'b0;
    ff_terms = ff;
    fb_terms = fb;
  endtask

  // Waits for every predicted output, then lets the pipeline drain so that a trailing
  // coefficient load has surely landed before the next register write.
  task automatic wait_quiet();
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random transaction: mostly samples, with coefficient loads, restarts and the
  // unused action mixed in. Fields a transaction does not use still carry random
  // bits, so the core must ignore them.
  function automatic stim_t random_item();
    stim_t s;
    int    pick;
    pick         = $urandom_range(0, 99);
    s.coef_index = 3'($urandom);
    s.coef_value = 18'($urandom);
    s.sample_in  = 16'($urandom);
    s.restart    = ($urandom_range(0, 24) == 0);
    s.fixed_exp  = 1'b0;
    s.exp_sample = '0;
    s.exp_sat    = 1'b0;
    if (pick < 6) s.action = ACT_LOAD_FF;
    else if (pick < 12) s.action = ACT_LOAD_FB;
    else if (pick < 14) s.action = ACT_UNUSED;
    else s.action = ACT_SAMPLE;
    // Most coefficients stay within +-1/8 so that seven feedback taps cannot make the
    // loop unstable; the rest span the full Q2.15 range and drive it into clipping.
    if (s.action != ACT_SAMPLE && $urandom_range(0, 3) != 0)
      s.coef_value = 18'(int'($urandom_range(0, 8191)) - 4096);
    if (s.action == ACT_SAMPLE && $urandom_range(0, 15) == 0)
      s.sample_in = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    return s;
  endfunction

  // Output side: checks every accepted transaction against the oldest prediction and
  // chooses the next tready. A hold request from the stimulus makes it hold tready low,
  // which backs the core up until it stops taking input.
  initial begin : result_sink
    result_t want;
    int      hold_left;
    hold_left  = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_outputs.size() == 0) begin
          $error("sample_out: unexpected transaction carrying %0d", $signed(out_tdata));
          error_count++;
        end else begin
          want = pending_outputs.pop_front();
          if (out_tdata !== want.sample_out) begin
            $error("sample_out: expected %0d, got %0d",
                   $signed(want.sample_out), $signed(out_tdata));
            error_count++;
          end
          if (out_tuser[0] !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, out_tuser[0]);
            error_count++;
          end
        end
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Ends the run if neither stream completes a transaction for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    stim_t s;
    int    n;

    // Directed rows. The core starts with one feedforward tap and no feedback taps, so
    // with b0 at 1.0 a sample passes straight through; with b0 at the Q2.15 extremes
    // (just under +4.0 and exactly -4.0) full-scale samples clip either way. Every
    // coefficient is written here, before any configuration can read it.
    //                action       index  coefficient    sample        rst   fixed  out       sat
    directed_tbl = '{
      '{ACT_LOAD_FF, 3'd0, 18'sd32768,   16'sd0,       1'b0, 1'b0, 16'h0000, 1'b0},
      '{ACT_SAMPLE,  3'd0, 18'sd0,       16'sh7FFF,    1'b1, 1'b1, 16'h7FFF, 1'b0},
      '{ACT_SAMPLE,  3'd7, 18'sh3FFFF,   16'sh8000,    1'b0, 1'b1, 16'h8000, 1'b0},
      '{ACT_SAMPLE,  3'd0, 18'sd0,       16'sd0,       1'b0, 1'b1, 16'h0000, 1'b0},
      // Restart is meaningless on a load and must leave the histories alone.
      '{ACT_LOAD_FF, 3'd0, 18'sh1FFFF,   16'sd0,       1'b1, 1'b0, 16'h0000, 1'b0},
      '{ACT_SAMPLE,  3'd0, 18'sd0,       16'sh7FFF,    1'b0, 1'b1, 16'h7FFF, 1'b1},
      '{ACT_LOAD_FF, 3'd0, 18'sh20000,   16'sd0,       1'b0, 1'b0, 16'h0000, 1'b0},
      '{ACT_SAMPLE,  3'd0, 18'sd0,       16'sh7FFF,    1'b0, 1'b1, 16'h8000, 1'b1},
      '{ACT_SAMPLE,  3'd0, 18'sd0,       16'sh8000,    1'b0, 1'b1, 16'h7FFF, 1'b1},
      // The unused action, all other bits set: no effect and no output.
      '{ACT_UNUSED,  3'd7, 18'sh3FFFF,   16'shFFFF,    1'b1, 1'b0, 16'h0000, 1'b0},
      '{ACT_LOAD_FF, 3'd1, 18'sd8192,    16'sd0,       1'b0, 1'b0, 16'h0000, 1'b0},
      '{ACT_LOAD_FF, 3'd2, -18'sd4096,   16'sd0,       1'b0, 1'b0, 16'h0000, 1'b0},
      '{ACT_LOAD_FF, 3'd3, 18'sd2048,    16'sd0,       1'b0, 1'b0, 16'h0000, 1'b0},
      '{ACT_LOAD_FF, 3'd4, -18'sd1024,   16'sd0,       1'b0, 1'b0, 16'h0000, 1'b0},
      '{ACT_LOAD_FF, 3'd5, 18'sd3000,    16'sd0,       1'b0, 1'b0, 16'h0000, 1'b0},
      '{ACT_LOAD_FF, 3'd6, -18'sd700,    16'sd0,       1'b0, 1'b0, 16'h0000, 1'b0},
      '{ACT_LOAD_FF, 3'd7, 18'sd1500,    16'sd0,       1'b0, 1'b0, 16'h0000, 1'b0},
      '{ACT_LOAD_FB, 3'd0, -18'sd4000,   16'sd0,       1'b0, 1'b0, 16'h0000, 1'b0},
      '{ACT_LOAD_FB, 3'd1, 18'sd2500,    16'sd0,       1'b0, 1'b0, 16'h0000, 1'b0},
      '{ACT_LOAD_FB, 3'd2, -18'sd1200,   16'sd0,       1'b0, 1'b0, 16'h0000, 1'b0},
      '{ACT_LOAD_FB, 3'd3, 18'sd900,     16'sd0,       1'b0, 1'b0, 16'h0000, 1'b0},
      '{ACT_LOAD_FB, 3'd4, -18'sd600,    16'sd0,       1'b0, 1'b0, 16'h0000, 1'b0},
      '{ACT_LOAD_FB, 3'd5, 18'sd300,     16'sd0,       1'b0, 1'b0, 16'h0000, 1'b0},
      '{ACT_LOAD_FB, 3'd6, -18'sd150,    16'sd0,       1'b0, 1'b0, 16'h0000, 1'b0},
      // Feedback index 7 names a8, which does not exist in an 8-tap core.
      '{ACT_LOAD_FB, 3'd7, 18'sh1FFFF,   16'sd0,       1'b0, 1'b0, 16'h0000, 1'b0},
      '{ACT_SAMPLE,  3'd0, 18'sd0,       16'sd12345,   1'b0, 1'b0, 16'h0000, 1'b0}
    };

    // Random phases. They cover the tap-count extremes, a feedforward count above the
    // tap limit, zero feedforward taps with full feedback, and every idling pattern.
    //              ff     fb    send rx   hold items
    phase_tbl = '{
      '{4'd8,  3'd7, 0,   0,   0,   80},
      '{4'd4,  3'd2, 61,  0,   0,   80},
      '{4'd15, 3'd0, 0,   61,  0,   80},
      '{4'd0,  3'd7, 34,  34,  0,   80},
      '{4'd1,  3'd1, 0,   0,   300, 80},
      '{4'd8,  3'd7, 34,  34,  0,   80}
    };

    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;

    // Predictor reset state matches the core's register reset values.
    for (n = 0; n < TAPS; n++) begin
      x_hist[n] = '0;
      y_hist[n] = '0;
      b_coef[n] = '0;
      a_coef[n] = '0;
    end
    ff_terms = 4'd1;
    fb_terms = 3'd0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_tbl[i]) offer(directed_tbl[i]);
    in_tvalid <= 1'b0;

    foreach (phase_tbl[p]) begin
      wait_quiet();
      write_tap_counts(phase_tbl[p].ff, phase_tbl[p].fb);
      send_idle_pct = phase_tbl[p].send_idle;
      rx_stall_pct  = phase_tbl[p].rx_stall;
      hold_request  = phase_tbl[p].hold;
      n = 0;
      while (n < phase_tbl[p].items) begin
        s = random_item();
        offer(s);
        // Transactions the core simply drops do not count toward the phase length.
        if (s.action == ACT_SAMPLE || s.action == ACT_LOAD_FF ||
            (s.action == ACT_LOAD_FB && s.coef_index != 3'd7))
          n++;
      end
      in_tvalid <= 1'b0;
    end

    wait_quiet();
    if (error_count == 0 && pending_outputs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
